/* rtl/core/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define STT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// clocked check, also active in reset
`define STT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/stt_pkg.sv */
package stt_pkg;

	localparam longint unsigned STT_MAX_SOURCE_BYTES = 64'd65535;
	localparam int unsigned STT_QUEUE_DEPTH = 4;

	localparam logic [15:0] STT_LEN_MAX = 16'hFFFF;
	localparam logic [62:0] STT_VALUE_ZERO = 63'd0;

	typedef enum logic [4:0] {
		K_END, K_NUMBER, K_IDENT,
		K_LET, K_IF, K_ELSE, K_WHILE, K_FN, K_RETURN,
		K_LE, K_GE, K_EQ, K_NE,
		K_PLUS, K_MINUS, K_STAR, K_SLASH,
		K_LT, K_GT, K_ASSIGN,
		K_LPAREN, K_RPAREN, K_LBRACE, K_RBRACE, K_COMMA, K_SEMI,
		K_BAD, K_OVERFLOW
	} stt_kind_t;

	typedef enum logic [2:0] {
		MODE_IDLE, MODE_NUMBER, MODE_IDENT, MODE_OPER, MODE_COMMENT, MODE_ERROR
	} stt_mode_t;

	typedef logic [5:0][7:0] stt_prefix_t;

	localparam stt_prefix_t KW_LET    = {24'h0, "tel"};
	localparam stt_prefix_t KW_IF     = {32'h0, "fi"};
	localparam stt_prefix_t KW_ELSE   = {16'h0, "esle"};
	localparam stt_prefix_t KW_WHILE  = {8'h0, "elihw"};
	localparam stt_prefix_t KW_FN     = {32'h0, "nf"};
	localparam stt_prefix_t KW_RETURN = "nruter";

	typedef struct packed {
		logic       is_end;
		logic [7:0] ch;
		logic       space;
		logic       digit;
		logic [3:0] dval;
		logic       wfirst;
		logic       wrest;
		logic       opstart;
		stt_kind_t  single;
		logic       newline;
		logic       is_eq;
		logic       is_slash;
	} stt_item_t;

	typedef struct packed {
		logic        last;
		logic [15:0] len;
		logic [15:0] start;
		logic [62:0] value;
		stt_kind_t   kind;
	} stt_res_t;

	function automatic stt_kind_t single_kind(input logic [7:0] c);
		case (c)
			"+": return K_PLUS;
			"-": return K_MINUS;
			"*": return K_STAR;
			"/": return K_SLASH;
			"<": return K_LT;
			">": return K_GT;
			"=": return K_ASSIGN;
			"(": return K_LPAREN;
			")": return K_RPAREN;
			"{": return K_LBRACE;
			"}": return K_RBRACE;
			",": return K_COMMA;
			";": return K_SEMI;
			default: return K_END;
		endcase
	endfunction

	function automatic stt_kind_t pair_kind(input logic [7:0] c);
		case (c)
			"<": return K_LE;
			">": return K_GE;
			"=": return K_EQ;
			"!": return K_NE;
			default: return K_END;
		endcase
	endfunction

	function automatic stt_kind_t word_kind(input stt_prefix_t p, input logic [15:0] len);
		if (len == 16'd3 && p == KW_LET) return K_LET;
		if (len == 16'd2 && p == KW_IF) return K_IF;
		if (len == 16'd4 && p == KW_ELSE) return K_ELSE;
		if (len == 16'd5 && p == KW_WHILE) return K_WHILE;
		if (len == 16'd2 && p == KW_FN) return K_FN;
		if (len == 16'd6 && p == KW_RETURN) return K_RETURN;
		return K_IDENT;
	endfunction

	function automatic logic [15:0] len_inc(input logic [15:0] x);
		return (x != STT_LEN_MAX) ? x + 16'd1 : x;
	endfunction

	function automatic stt_res_t mk_res(input stt_kind_t kind, input logic [62:0] value,
			input logic [15:0] start, input logic [15:0] len);
		stt_res_t r;
		r.last  = 1'b0;
		r.len   = len;
		r.start = start;
		r.value = value;
		r.kind  = kind;
		return r;
	endfunction

endpackage

/* rtl/core/stt_queue.sv */
module stt_queue import stt_pkg::*; #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = STT_QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en0,
	input  logic [WIDTH-1:0]           wr_data0,
	input  logic                       wr_en1,
	input  logic [WIDTH-1:0]           wr_data1,
	input  logic                       rd_en,
	output logic [WIDTH-1:0]           rd_data,
	output logic                       rd_valid,
	output logic [$clog2(DEPTH):0]     count
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = AW + 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic [AW-1:0]    wr_ptr1;

	assign wr_ptr1  = AW'(wr_ptr_q + 1'b1);
	assign rd_data  = mem_q[rd_ptr_q];
	assign rd_valid = (count_q != '0);
	assign count    = count_q;

	always_ff @(posedge clk) begin
		if (wr_en0) begin
			mem_q[wr_ptr_q] <= wr_data0;
		end
		if (wr_en1) begin
			mem_q[wr_ptr1] <= wr_data1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= AW'(wr_ptr_q + AW'(wr_en0) + AW'(wr_en1));
			rd_ptr_q <= AW'(rd_ptr_q + AW'(rd_en));
			count_q  <= CW'(count_q + CW'(wr_en0) + CW'(wr_en1) - CW'(rd_en));
		end
	end

endmodule

/* rtl/core/stt_front.sv */
module stt_front import stt_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = STT_QUEUE_DEPTH
) (
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,
	input  logic                          s_tuser,
	input  logic [$clog2(QUEUE_DEPTH):0]  q_count,
	output logic                          q_push,
	output stt_item_t                     q_item
);

	localparam int unsigned CW = $clog2(QUEUE_DEPTH) + 1;

	logic [7:0] c;
	logic       alpha;
	logic       digit;

	assign c        = s_tdata;
	assign s_tready = (q_count < CW'(QUEUE_DEPTH));
	assign q_push   = s_tvalid && s_tready;

	assign digit = (c >= "0") && (c <= "9");
	assign alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));

	always_comb begin
		q_item.is_end   = s_tuser;
		q_item.ch       = c;
		q_item.space    = (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
		q_item.digit    = digit;
		q_item.dval     = c[3:0];
		q_item.wfirst   = alpha || (c == "_");
		q_item.wrest    = alpha || digit || (c == "_");
		q_item.opstart  = (c == "<") || (c == ">") || (c == "=") || (c == "!") || (c == "/");
		q_item.single   = single_kind(c);
		q_item.newline  = (c == 8'd10);
		q_item.is_eq    = (c == "=");
		q_item.is_slash = (c == "/");
	end

endmodule

/* rtl/core/stt_back.sv */
module stt_back import stt_pkg::*; #(
	parameter longint unsigned MAX_SOURCE_BYTES = STT_MAX_SOURCE_BYTES,
	parameter int unsigned     QUEUE_DEPTH      = STT_QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	input  stt_item_t                     item,
	output logic                          item_pop,
	input  logic [$clog2(QUEUE_DEPTH):0]  res_count,
	output logic                          res_push0,
	output stt_res_t                      res0,
	output logic                          res_push1,
	output stt_res_t                      res1
);

	localparam int unsigned CW = $clog2(QUEUE_DEPTH) + 1;
	localparam logic [15:0] POS_LIMIT =
		(MAX_SOURCE_BYTES < 64'd65535) ? 16'(MAX_SOURCE_BYTES) : 16'hFFFF;

	stt_mode_t   mode_q, mode_d;
	logic [62:0] accum_q, accum_d;
	logic [15:0] pos_q, pos_d;
	logic [15:0] start_q, start_d;
	logic [15:0] len_q, len_d;
	stt_prefix_t prefix_q, prefix_d;
	logic [7:0]  pend_q, pend_d;

	logic [66:0] prod;
	logic        ovf;
	stt_mode_t   f_mode;
	logic        f_emit;
	stt_kind_t   f_kind;
	logic        take_fresh;
	logic [1:0]  cnt;
	stt_res_t    res_d [2];
	stt_kind_t   pk;

	assign item_pop = item_valid && (res_count <= CW'(QUEUE_DEPTH - 2));

	assign prod = {1'b0, accum_q, 3'b000} + {3'b000, accum_q, 1'b0} + {63'd0, item.dval};
	assign ovf  = |prod[66:63];
	assign pk   = pair_kind(pend_q);

	always_comb begin
		f_mode = MODE_IDLE;
		f_emit = 1'b0;
		f_kind = K_END;
		if (item.space) begin
			f_mode = MODE_IDLE;
		end else if (item.digit) begin
			f_mode = MODE_NUMBER;
		end else if (item.wfirst) begin
			f_mode = MODE_IDENT;
		end else if (item.opstart) begin
			f_mode = MODE_OPER;
		end else if (item.single != K_END) begin
			f_emit = 1'b1;
			f_kind = item.single;
		end else begin
			f_emit = 1'b1;
			f_kind = K_BAD;
			f_mode = MODE_ERROR;
		end
	end

	always_comb begin
		mode_d     = mode_q;
		accum_d    = accum_q;
		pos_d      = pos_q;
		start_d    = start_q;
		len_d      = len_q;
		prefix_d   = prefix_q;
		pend_d     = pend_q;
		take_fresh = 1'b0;
		cnt        = 2'd0;
		res_d[0]   = '0;
		res_d[1]   = '0;

		if (item.is_end) begin
			case (mode_q)
				MODE_NUMBER: begin
					res_d[cnt[0]] = mk_res(K_NUMBER, accum_q, start_q, len_q);
					cnt = cnt + 2'd1;
				end
				MODE_IDENT: begin
					res_d[cnt[0]] = mk_res(word_kind(prefix_q, len_q), STT_VALUE_ZERO,
						start_q, len_q);
					cnt = cnt + 2'd1;
				end
				MODE_OPER: begin
					res_d[cnt[0]] = mk_res((pend_q == "!") ? K_BAD : single_kind(pend_q),
						STT_VALUE_ZERO, start_q, 16'd1);
					cnt = cnt + 2'd1;
				end
				default: begin
				end
			endcase
			res_d[cnt[0]] = mk_res(K_END, STT_VALUE_ZERO, pos_q, 16'd0);
			cnt = cnt + 2'd1;
			mode_d   = MODE_IDLE;
			accum_d  = '0;
			pos_d    = '0;
			start_d  = '0;
			len_d    = '0;
			prefix_d = '0;
			pend_d   = '0;
		end else begin
			case (mode_q)
				MODE_NUMBER: begin
					if (item.digit) begin
						if (ovf) begin
							res_d[cnt[0]] = mk_res(K_OVERFLOW, STT_VALUE_ZERO, start_q,
								len_inc(len_q));
							cnt = cnt + 2'd1;
							mode_d = MODE_ERROR;
						end else begin
							accum_d = prod[62:0];
							len_d   = len_inc(len_q);
						end
					end else begin
						res_d[cnt[0]] = mk_res(K_NUMBER, accum_q, start_q, len_q);
						cnt = cnt + 2'd1;
						take_fresh = 1'b1;
					end
				end
				MODE_IDENT: begin
					if (item.wrest) begin
						if (len_q < 16'd6) begin
							prefix_d[len_q[2:0]] = item.ch;
						end
						len_d = len_inc(len_q);
					end else begin
						res_d[cnt[0]] = mk_res(word_kind(prefix_q, len_q), STT_VALUE_ZERO,
							start_q, len_q);
						cnt = cnt + 2'd1;
						take_fresh = 1'b1;
					end
				end
				MODE_OPER: begin
					if ((pend_q == "/") && item.is_slash) begin
						mode_d = MODE_COMMENT;
					end else if (item.is_eq && (pk != K_END)) begin
						res_d[cnt[0]] = mk_res(pk, STT_VALUE_ZERO, start_q, 16'd2);
						cnt = cnt + 2'd1;
						mode_d = MODE_IDLE;
					end else if (pend_q == "!") begin
						res_d[cnt[0]] = mk_res(K_BAD, STT_VALUE_ZERO, start_q, 16'd1);
						cnt = cnt + 2'd1;
						mode_d = MODE_ERROR;
					end else begin
						res_d[cnt[0]] = mk_res(single_kind(pend_q), STT_VALUE_ZERO,
							start_q, 16'd1);
						cnt = cnt + 2'd1;
						take_fresh = 1'b1;
					end
				end
				MODE_COMMENT: begin
					if (item.newline) begin
						mode_d = MODE_IDLE;
					end
				end
				MODE_ERROR: begin
				end
				default: begin
					take_fresh = 1'b1;
				end
			endcase

			if (take_fresh) begin
				mode_d = f_mode;
				if (item.digit) begin
					accum_d = {59'd0, item.dval};
					start_d = pos_q;
					len_d   = 16'd1;
				end else if (item.wfirst) begin
					prefix_d    = '0;
					prefix_d[0] = item.ch;
					start_d     = pos_q;
					len_d       = 16'd1;
				end else if (item.opstart) begin
					pend_d  = item.ch;
					start_d = pos_q;
				end
				if (f_emit) begin
					res_d[cnt[0]] = mk_res(f_kind, STT_VALUE_ZERO, pos_q, 16'd1);
					cnt = cnt + 2'd1;
				end
			end

			if (pos_q < POS_LIMIT) begin
				pos_d = pos_q + 16'd1;
			end
		end

		if (cnt == 2'd2) begin
			res_d[1].last = 1'b1;
		end else if (cnt == 2'd1) begin
			res_d[0].last = 1'b1;
		end
	end

	assign res0      = res_d[0];
	assign res1      = res_d[1];
	assign res_push0 = item_pop && (cnt != 2'd0);
	assign res_push1 = item_pop && (cnt == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			accum_q  <= '0;
			pos_q    <= '0;
			start_q  <= '0;
			len_q    <= '0;
			prefix_q <= '0;
			pend_q   <= '0;
		end else if (item_pop) begin
			mode_q   <= mode_d;
			accum_q  <= accum_d;
			pos_q    <= pos_d;
			start_q  <= start_d;
			len_q    <= len_d;
			prefix_q <= prefix_d;
			pend_q   <= pend_d;
		end
	end

endmodule

/* rtl/core/source_text_tokenizer.sv */
// Source text tokenizer: scans a byte stream into tokens.
// Input words carry one source byte in s_tdata, or an end-of-source mark
// when s_tuser is high. Output words carry one token: number value, start
// offset and length in m_tdata, the token kind in m_tuser; m_tlast marks the
// final token caused by one input word (each input word yields zero, one or
// two tokens).
// A front stage classifies each byte into a 4-entry item queue; the back
// stage runs the scanner state and, while the result queue has room for two,
// writes up to two tokens a cycle into a 4-entry result queue that drives m_*.
// A token reaches m_* once the byte that ends it has passed the item queue and
// been written into the result queue. One input word is taken per cycle while
// the queues have room; a word's two tokens leave the single read port in turn.
// Reset empties both queues and returns the scanner to idle at offset 0.
// When the receiver stalls, the result queue fills, the back stage stops
// taking items, the item queue fills and s_tready drops; nothing is lost.
`include "assert_macros.svh"

module source_text_tokenizer import stt_pkg::*; #(
	parameter longint unsigned MAX_SOURCE_BYTES = STT_MAX_SOURCE_BYTES,
	parameter int unsigned     QUEUE_DEPTH      = STT_QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // char_byte
	input  logic         s_tuser,   // op
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata,   // number_value, start_offset, token_length
	output logic [4:0]   m_tuser,   // token_kind
	output logic         m_tlast
);

	localparam int unsigned CW = $clog2(QUEUE_DEPTH) + 1;
	localparam int unsigned ITEM_W = $bits(stt_item_t);
	localparam int unsigned RES_W  = $bits(stt_res_t);

	logic            q_push;
	stt_item_t       q_item;
	logic [CW-1:0]   item_count;
	logic            item_valid;
	logic            item_pop;
	stt_item_t       item;
	logic [CW-1:0]   res_count;
	logic            res_push0;
	logic            res_push1;
	stt_res_t        res0;
	stt_res_t        res1;
	stt_res_t        head;
	logic            m_pop;

	stt_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.q_count (item_count),
		.q_push  (q_push),
		.q_item  (q_item)
	);

	stt_queue #(
		.WIDTH(ITEM_W),
		.DEPTH(QUEUE_DEPTH)
	) u_item_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en0  (q_push),
		.wr_data0(q_item),
		.wr_en1  (1'b0),
		.wr_data1(q_item),
		.rd_en   (item_pop),
		.rd_data (item),
		.rd_valid(item_valid),
		.count   (item_count)
	);

	stt_back #(
		.MAX_SOURCE_BYTES(MAX_SOURCE_BYTES),
		.QUEUE_DEPTH     (QUEUE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item      (item),
		.item_pop  (item_pop),
		.res_count (res_count),
		.res_push0 (res_push0),
		.res0      (res0),
		.res_push1 (res_push1),
		.res1      (res1)
	);

	stt_queue #(
		.WIDTH(RES_W),
		.DEPTH(QUEUE_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en0  (res_push0),
		.wr_data0(res0),
		.wr_en1  (res_push1),
		.wr_data1(res1),
		.rd_en   (m_pop),
		.rd_data (head),
		.rd_valid(m_tvalid),
		.count   (res_count)
	);

	assign m_pop   = m_tvalid && m_tready;
	assign m_tdata = {1'b0, head.len, head.start, head.value};
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

	`STT_ASSERT(a_res_q_bound, res_count <= CW'(QUEUE_DEPTH), "result queue overflow")
	`STT_ASSERT(a_pop_nonempty, item_pop |-> item_count != '0, "pop from empty item queue")
	`STT_ASSERT(a_end_is_last, (m_tvalid && head.kind == K_END) |-> m_tlast, "end token not last")
	`STT_ASSERT(a_pair_order, res_push1 |-> res_push0 && !res0.last && res1.last, "bad token pair")

endmodule

/* test/source_text_tokenizer_tb.sv */
module source_text_tokenizer_tb;
	import stt_pkg::*;

	localparam longint unsigned INT63_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [15:0] POS_LIMIT = (STT_MAX_SOURCE_BYTES < 64'd65535) ?
		16'(STT_MAX_SOURCE_BYTES) : 16'hFFFF;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		stt_kind_t   kind;
		logic [62:0] value;
		logic [15:0] start;
		logic [15:0] len;
		logic        last;
	} token_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = 8'h00;
	logic         s_tuser = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [95:0]  m_tdata;
	logic [4:0]   m_tuser;
	logic         m_tlast;

	source_text_tokenizer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #5 clk = ~clk;

	token_t expected_tokens[$];
	int mismatch_count = 0;
	int tokens_checked = 0;
	int words_sent = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;

	stt_mode_t       sc_mode;
	longint unsigned sc_accum;
	logic [15:0]     sc_pos;
	logic [15:0]     sc_start;
	logic [15:0]     sc_len;
	logic [7:0]      sc_prefix [0:5];
	logic [7:0]      sc_pend;

	function automatic bit is_blank(input logic [7:0] c);
		return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic bit is_num(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic [15:0] bump(input logic [15:0] x);
		return (x < 16'hFFFF) ? x + 16'd1 : x;
	endfunction

	function automatic stt_kind_t lone_kind(input logic [7:0] c);
		case (c)
			"+": return K_PLUS;
			"-": return K_MINUS;
			"*": return K_STAR;
			"/": return K_SLASH;
			"<": return K_LT;
			">": return K_GT;
			"=": return K_ASSIGN;
			"(": return K_LPAREN;
			")": return K_RPAREN;
			"{": return K_LBRACE;
			"}": return K_RBRACE;
			",": return K_COMMA;
			";": return K_SEMI;
			default: return K_END;
		endcase
	endfunction

	function automatic stt_kind_t double_kind(input logic [7:0] c);
		case (c)
			"<": return K_LE;
			">": return K_GE;
			"=": return K_EQ;
			"!": return K_NE;
			default: return K_END;
		endcase
	endfunction

	function automatic string keyword_text(input int k);
		case (k)
			0: return "let";
			1: return "if";
			2: return "else";
			3: return "while";
			4: return "fn";
			default: return "return";
		endcase
	endfunction

	function automatic stt_kind_t ident_kind();
		string s;
		bit hit;
		for (int k = 0; k < 6; k++) begin
			s = keyword_text(k);
			hit = (sc_len == s.len());
			for (int i = 0; i < s.len(); i++)
				if (sc_prefix[i] != s[i]) hit = 1'b0;
			if (hit) return stt_kind_t'(K_LET + k);
		end
		return K_IDENT;
	endfunction

	task automatic scanner_clear();
		sc_mode = MODE_IDLE;
		sc_accum = 0;
		sc_pos = 16'd0;
		sc_start = 16'd0;
		sc_len = 16'd0;
		for (int i = 0; i < 6; i++) sc_prefix[i] = 8'h00;
		sc_pend = 8'h00;
	endtask

	task automatic add_token(input stt_kind_t kind, input logic [62:0] value,
			input logic [15:0] start, input logic [15:0] len);
		token_t t;
		t.kind = kind;
		t.value = value;
		t.start = start;
		t.len = len;
		t.last = 1'b0;
		expected_tokens = {expected_tokens, t};
	endtask

	task automatic flush_oper();
		if (sc_pend == "!") begin
			add_token(K_BAD, 0, sc_start, 16'd1);
			sc_mode = MODE_ERROR;
		end else begin
			add_token(lone_kind(sc_pend), 0, sc_start, 16'd1);
			sc_mode = MODE_IDLE;
		end
	endtask

	task automatic scan_fresh(input logic [7:0] c, input logic [15:0] p);
		stt_kind_t k;
		sc_mode = MODE_IDLE;
		if (is_blank(c)) return;
		if (is_num(c)) begin
			sc_mode = MODE_NUMBER;
			sc_accum = 64'(c - 8'h30);
			sc_start = p;
			sc_len = 16'd1;
			return;
		end
		if (is_letter(c) || c == "_") begin
			sc_mode = MODE_IDENT;
			for (int i = 0; i < 6; i++) sc_prefix[i] = 8'h00;
			sc_prefix[0] = c;
			sc_len = 16'd1;
			sc_start = p;
			return;
		end
		if (c == "<" || c == ">" || c == "=" || c == "!" || c == "/") begin
			sc_mode = MODE_OPER;
			sc_pend = c;
			sc_start = p;
			return;
		end
		k = lone_kind(c);
		if (k != K_END) begin
			add_token(k, 0, p, 16'd1);
		end else begin
			add_token(K_BAD, 0, p, 16'd1);
			sc_mode = MODE_ERROR;
		end
	endtask

	task automatic predict_tokens(input logic op, input logic [7:0] c);
		int before_cnt;
		logic [15:0] p;
		longint unsigned d;
		before_cnt = expected_tokens.size();
		p = sc_pos;
		if (op) begin
			case (sc_mode)
				MODE_NUMBER: add_token(K_NUMBER, sc_accum[62:0], sc_start, sc_len);
				MODE_IDENT: add_token(ident_kind(), 0, sc_start, sc_len);
				MODE_OPER: flush_oper();
				default: ;
			endcase
			add_token(K_END, 0, p, 16'd0);
			scanner_clear();
		end else begin
			case (sc_mode)
				MODE_NUMBER: begin
					if (is_num(c)) begin
						d = 64'(c - 8'h30);
						if (sc_accum > (INT63_MAX - d) / 10) begin
							add_token(K_OVERFLOW, 0, sc_start, bump(sc_len));
							sc_mode = MODE_ERROR;
						end else begin
							sc_accum = sc_accum * 10 + d;
							sc_len = bump(sc_len);
						end
					end else begin
						add_token(K_NUMBER, sc_accum[62:0], sc_start, sc_len);
						scan_fresh(c, p);
					end
				end
				MODE_IDENT: begin
					if (is_letter(c) || is_num(c) || c == "_") begin
						if (sc_len < 16'd6) sc_prefix[sc_len] = c;
						sc_len = bump(sc_len);
					end else begin
						add_token(ident_kind(), 0, sc_start, sc_len);
						scan_fresh(c, p);
					end
				end
				MODE_OPER: begin
					if (sc_pend == "/" && c == "/") begin
						sc_mode = MODE_COMMENT;
					end else if (c == "=" && double_kind(sc_pend) != K_END) begin
						add_token(double_kind(sc_pend), 0, sc_start, 16'd2);
						sc_mode = MODE_IDLE;
					end else begin
						flush_oper();
						if (sc_mode != MODE_ERROR) scan_fresh(c, p);
					end
				end
				MODE_COMMENT: begin
					if (c == 8'd10) sc_mode = MODE_IDLE;
				end
				MODE_ERROR: ;
				default: scan_fresh(c, p);
			endcase
			if (p < POS_LIMIT) sc_pos = p + 16'd1;
		end
		if (expected_tokens.size() > before_cnt) begin
			expected_tokens[expected_tokens.size() - 1].last = 1'b1;
		end
	endtask

	task automatic send_word(input logic op, input logic [7:0] ch);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= ch;
		s_tuser <= op;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		words_sent++;
		predict_tokens(op, ch);
	endtask

	task automatic send_char(input logic [7:0] c);
		send_word(1'b0, c);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_char(s[i]);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_tokens.size() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] blank_char();
		case ($urandom_range(5))
			0: return 8'd32;
			1: return 8'd9;
			2: return 8'd10;
			3: return 8'd11;
			4: return 8'd12;
			default: return 8'd13;
		endcase
	endfunction

	function automatic logic [7:0] word_char(input bit first);
		int r;
		r = first ? $urandom_range(52) : $urandom_range(62);
		if (r < 26) return 8'("a" + r);
		if (r < 52) return 8'("A" + r - 26);
		if (r == 52) return "_";
		return 8'("0" + r - 53);
	endfunction

	function automatic logic [7:0] digit_char();
		return 8'("0" + $urandom_range(9));
	endfunction

	function automatic string oper_text();
		case ($urandom_range(16))
			0: return "<=";
			1: return ">=";
			2: return "==";
			3: return "!=";
			4: return "<";
			5: return ">";
			6: return "=";
			7: return "+";
			8: return "-";
			9: return "*";
			10: return "/";
			11: return "(";
			12: return ")";
			13: return "{";
			14: return "}";
			15: return ",";
			default: return ";";
		endcase
	endfunction

	task automatic send_random_token();
		int r;
		int n;
		string s;
		logic [7:0] b;
		r = $urandom_range(99);
		if (r < 15) begin
			s = keyword_text($urandom_range(5));
			case ($urandom_range(3))
				0: s = s.substr(0, s.len() - 2);
				1: begin
					send_text(s);
					s = "";
					send_char(word_char(1'b0));
				end
				default: ;
			endcase
			send_text(s);
		end else if (r < 35) begin
			send_char(word_char(1'b1));
			n = ($urandom_range(9) == 0) ? $urandom_range(30) : $urandom_range(6);
			repeat (n) send_char(word_char(1'b0));
		end else if (r < 55) begin
			case ($urandom_range(19))
				0: send_text("9223372036854775807");
				1: send_text("9223372036854775808");
				2: repeat (20) send_char(digit_char());
				3: begin
					repeat ($urandom_range(1, 4)) send_char("0");
					repeat ($urandom_range(0, 5)) send_char(digit_char());
				end
				default: repeat ($urandom_range(1, 12)) send_char(digit_char());
			endcase
		end else if (r < 80) begin
			send_text(oper_text());
		end else if (r < 88) begin
			send_text("//");
			repeat ($urandom_range(8)) begin
				do b = 8'($urandom_range(255)); while (b == 8'd10);
				send_char(b);
			end
			if ($urandom_range(9) < 8) send_char(8'd10);
		end else if (r < 94) begin
			send_char(blank_char());
		end else begin
			case ($urandom_range(2))
				0: send_char(8'($urandom_range(255)));
				1: begin
					send_char("!");
					send_char(8'($urandom_range(255)));
				end
				default: send_char(8'd128 + 8'($urandom_range(127)));
			endcase
		end
	endtask

	task automatic test_directed();
		tx_idle_pct = 19;
		rx_idle_pct = 65;
		send_text("x<=1!");
		send_word(1'b1, 8'hFF);
		send_text("// c");
		send_word(1'b1, 8'h00);
		send_char(8'h80);
		send_char("a");
		send_word(1'b1, 8'h00);
		send_text("/=");
		send_word(1'b1, 8'h00);
		send_text("!a");
		send_word(1'b1, 8'h00);
		wait_drained();
	endtask

	task automatic test_random_phase(input int tx, input int rx, input int n_words);
		int stop_at;
		tx_idle_pct = tx;
		rx_idle_pct = rx;
		stop_at = words_sent + n_words;
		while (words_sent < stop_at) begin
			repeat ($urandom_range(1, 12)) begin
				send_random_token();
				if ($urandom_range(99) < 60) send_char(blank_char());
			end
			send_word(1'b1, 8'($urandom_range(255)));
		end
		wait_drained();
	endtask

	task automatic test_backpressure();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_req++;
		repeat (60) send_char($urandom_range(1) ? ";" : ")");
		send_word(1'b1, 8'h00);
		wait_drained();
	endtask

	task automatic test_long_tokens();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		repeat (40) send_char("a");
		send_char(" ");
		repeat (25) send_char("0");
		send_text("7 q");
		send_word(1'b1, 8'h00);
		wait_drained();
	endtask

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		if (mismatch_count < 40)
			$display("token %0d: %s got %0h expected %0h", tokens_checked, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin : check_tokens
		token_t seen;
		token_t want;
		if (arst_n && m_tvalid && m_tready) begin
			seen.kind = stt_kind_t'(m_tuser);
			seen.value = m_tdata[62:0];
			seen.start = m_tdata[78:63];
			seen.len = m_tdata[94:79];
			seen.last = m_tlast;
			if (expected_tokens.size() == 0) begin
				report_mismatch("unexpected token kind", 64'(seen.kind), 64'd0);
			end else begin
				want = expected_tokens.pop_front();
				if (seen.kind !== want.kind)
					report_mismatch("kind", 64'(seen.kind), 64'(want.kind));
				if (seen.value !== want.value)
					report_mismatch("value", 64'(seen.value), 64'(want.value));
				if (seen.start !== want.start)
					report_mismatch("start", 64'(seen.start), 64'(want.start));
				if (seen.len !== want.len)
					report_mismatch("length", 64'(seen.len), 64'(want.len));
				if (seen.last !== want.last)
					report_mismatch("last", 64'(seen.last), 64'(want.last));
			end
			tokens_checked++;
		end
	end

	initial begin
		#15_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		scanner_clear();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random_phase(19, 65, 380);
		test_random_phase(65, 19, 380);
		test_random_phase(0, 0, 380);
		test_backpressure();
		test_long_tokens();
		wait_drained();
		repeat (10) @(posedge clk);
		$display("Scanned %0d source words into %0d tokens: directed cases, random sources",
			words_sent, tokens_checked);
		$display("under three idle mixes, a long output stall and long words and numbers");
		if (mismatch_count == 0 && expected_tokens.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

/* source_text_tokenizer.f */
+incdir+rtl/core
rtl/core/stt_pkg.sv
rtl/core/stt_queue.sv
rtl/core/stt_front.sv
rtl/core/stt_back.sv
rtl/core/source_text_tokenizer.sv
test/source_text_tokenizer_tb.sv
